// ===== rtl/dorb_pkg.sv =====
// Display-order reorder buffer: shared constants, codes and types.
// No dependencies; compile first.
package dorb_pkg;

    localparam int SLOTS     = 16;
    localparam int TAG_BITS  = 8;
    localparam int ADDR_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int PTS_W     = 64;
    localparam int TAG_IN_W  = 8;
    localparam int MODE_W    = 2;
    localparam int KIND_W    = 2;
    localparam int DEPTH_W   = 4;
    localparam int CMP_W     = (CNT_W > DEPTH_W + 1) ? CNT_W : DEPTH_W + 1;

    localparam logic [DEPTH_W-1:0] DEPTH_RST = DEPTH_W'(4);

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EOS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PRESENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EOS     = 2'd2;

    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [TAG_BITS-1:0] t_tag;

    typedef struct packed {
        logic [PTS_W-1:0] pts;
        t_tag             tag;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic first;
        t_cnt idx;
    } t_scan_beat;

endpackage

// ===== rtl/dorb_in_if.sv =====
// Input channel of the reorder buffer: valid/ready plus one frame command.
// Depends on dorb_pkg.
interface dorb_in_if;
    logic                         valid;
    logic                         ready;
    logic [dorb_pkg::MODE_W-1:0]  mode;
    logic [dorb_pkg::PTS_W-1:0]   frame_pts;
    logic [dorb_pkg::TAG_IN_W-1:0] frame_tag;

    modport source (output valid, output mode, output frame_pts, output frame_tag,
                    input ready);
    modport sink   (input valid, input mode, input frame_pts, input frame_tag,
                    output ready);
endinterface

// ===== rtl/dorb_out_if.sv =====
// Output channel of the reorder buffer: valid/ready plus one emitted entry.
// Depends on dorb_pkg.
interface dorb_out_if;
    logic                          valid;
    logic                          ready;
    logic [dorb_pkg::KIND_W-1:0]   kind;
    logic [dorb_pkg::PTS_W-1:0]    out_pts;
    logic [dorb_pkg::TAG_IN_W-1:0] out_tag;
    logic                          last;

    modport source (output valid, output kind, output out_pts, output out_tag,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_pts, input out_tag,
                    input last, output ready);
endinterface

// ===== rtl/dorb_min_track.sv =====
// Running minimum over entries read back from the store, first entry wins ties.
// Depends on dorb_pkg.
module dorb_min_track (
    input  logic                 i_clk,
    input  dorb_pkg::t_scan_beat i_beat,
    input  dorb_pkg::t_entry     i_entry,
    output dorb_pkg::t_cnt       o_best_idx,
    output dorb_pkg::t_entry     o_best
);

    dorb_pkg::t_cnt   r_best_idx;
    dorb_pkg::t_entry r_best;

    always_ff @(posedge i_clk) begin
        if (i_beat.valid && (i_beat.first || (i_entry.pts < r_best.pts))) begin
            r_best     <= i_entry;
            r_best_idx <= i_beat.idx;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_best     = r_best;

endmodule

// ===== rtl/display_order_reorder_buffer.sv =====
// Display-order reorder buffer top level: entry store, sequencer, output register.
// Depends on dorb_pkg, dorb_in_if, dorb_out_if, dorb_min_track.
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------
//  i_in     | in  | mode, frame_pts, frame_tag
//  o_out    | out | kind, out_pts, out_tag, last
//  i_cfg_*  | in  | reorder_depth write (i_cfg_we, i_cfg_wdata)
//
// Push below threshold: the entry is written on accept. Pop (push at threshold or
// end-of-stream step): accept, scan the N held entries through the read port, emit
// the best, then move later entries down unless best is last. Clear: each held
// entry is read and emitted as a discard. End of stream on empty store emits EOS.
// Synchronous active-low reset clears state, count and output valid, loads depth
// with DEPTH_RST; the store needs no clearing. A stalled output holds the sequencer.
module display_order_reorder_buffer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dorb_in_if.sink                        i_in,
    dorb_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [dorb_pkg::DEPTH_W-1:0]   i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POP_OUT,
        S_SHIFT,
        S_EOS,
        S_CLR_RD,
        S_CLR_WT
    } t_state;

    t_state                        r_state;
    dorb_pkg::t_cnt                r_count;
    logic [dorb_pkg::DEPTH_W-1:0]  r_depth;
    dorb_pkg::t_cnt                r_rd_idx;
    logic                          r_pend;
    dorb_pkg::t_cnt                r_pend_idx;
    dorb_pkg::t_entry              r_rdata;

    logic                          r_out_valid;
    logic [dorb_pkg::KIND_W-1:0]   r_out_kind;
    logic [dorb_pkg::PTS_W-1:0]    r_out_pts;
    logic [dorb_pkg::TAG_IN_W-1:0] r_out_tag;
    logic                          r_out_last;

    dorb_pkg::t_entry              r_mem [dorb_pkg::SLOTS];

    logic                          w_acc;
    logic                          w_out_free;
    logic                          w_emit;
    dorb_pkg::t_cnt                n_count_push;
    dorb_pkg::t_cnt                w_cnt_m1;
    dorb_pkg::t_cnt                w_pend_m1;
    logic [dorb_pkg::DEPTH_W:0]    w_dp1;
    logic                          w_release;
    logic                          w_we;
    dorb_pkg::t_addr               w_waddr;
    dorb_pkg::t_entry              w_wdata;
    logic                          w_re;
    dorb_pkg::t_addr               w_raddr;
    dorb_pkg::t_scan_beat          w_beat;
    dorb_pkg::t_cnt                w_best_idx;
    dorb_pkg::t_entry              w_best;

    assign w_acc        = i_in.valid && (r_state == S_IDLE);
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_emit       = w_out_free && ((r_state == S_POP_OUT) || (r_state == S_EOS)
                                      || (r_state == S_CLR_WT));
    assign n_count_push = r_count + dorb_pkg::t_cnt'(1);
    assign w_cnt_m1     = r_count - dorb_pkg::t_cnt'(1);
    assign w_pend_m1    = r_pend_idx - dorb_pkg::t_cnt'(1);
    assign w_dp1        = {1'b0, r_depth} + (dorb_pkg::DEPTH_W + 1)'(1);
    assign w_release    = (n_count_push >= dorb_pkg::t_cnt'(dorb_pkg::SLOTS))
                       || (dorb_pkg::CMP_W'(n_count_push) >= dorb_pkg::CMP_W'(w_dp1));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[dorb_pkg::ADDR_W-1:0];
        w_wdata = '{pts: i_in.frame_pts, tag: dorb_pkg::t_tag'(i_in.frame_tag)};
        w_re    = 1'b0;
        w_raddr = r_rd_idx[dorb_pkg::ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                w_we = w_acc && (i_in.mode == dorb_pkg::MODE_PUSH);
            end
            S_SCAN: begin
                w_re = r_rd_idx < r_count;
            end
            S_SHIFT: begin
                w_re    = r_rd_idx <= r_count;
                w_we    = r_pend;
                w_waddr = w_pend_m1[dorb_pkg::ADDR_W-1:0];
                w_wdata = r_rdata;
            end
            S_CLR_RD: begin
                w_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign w_beat = '{valid: (r_state == S_SCAN) && r_pend,
                      first: (r_pend_idx == '0),
                      idx:   r_pend_idx};

    dorb_min_track u_min_track (
        .i_clk      (i_clk),
        .i_beat     (w_beat),
        .i_entry    (r_rdata),
        .o_best_idx (w_best_idx),
        .o_best     (w_best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_depth     <= dorb_pkg::DEPTH_RST;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_pend_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_depth <= i_cfg_wdata;
            end
            if (o_out.ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_pend   <= 1'b0;
                    r_rd_idx <= '0;
                    if (w_acc) begin
                        unique case (i_in.mode)
                            dorb_pkg::MODE_PUSH: begin
                                r_count <= n_count_push;
                                if (w_release) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            dorb_pkg::MODE_EOS: begin
                                r_state <= (r_count == '0) ? S_EOS : S_SCAN;
                            end
                            dorb_pkg::MODE_CLEAR: begin
                                if (r_count != '0) begin
                                    r_state <= S_CLR_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_pend     <= w_re;
                    r_pend_idx <= r_rd_idx;
                    if (w_re) begin
                        r_rd_idx <= r_rd_idx + dorb_pkg::t_cnt'(1);
                    end
                    if (r_pend && (r_pend_idx == w_cnt_m1)) begin
                        r_state <= S_POP_OUT;
                    end
                end
                S_POP_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= dorb_pkg::KIND_PRESENT;
                        r_out_pts   <= w_best.pts;
                        r_out_tag   <= dorb_pkg::TAG_IN_W'(w_best.tag);
                        r_out_last  <= 1'b1;
                        r_count     <= w_cnt_m1;
                        r_rd_idx    <= w_best_idx + dorb_pkg::t_cnt'(1);
                        r_pend      <= 1'b0;
                        r_state     <= (w_best_idx == w_cnt_m1) ? S_IDLE : S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_pend     <= w_re;
                    r_pend_idx <= r_rd_idx;
                    if (w_re) begin
                        r_rd_idx <= r_rd_idx + dorb_pkg::t_cnt'(1);
                    end
                    if (r_pend && (r_pend_idx == r_count)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EOS: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= dorb_pkg::KIND_EOS;
                        r_out_pts   <= '0;
                        r_out_tag   <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_CLR_RD: begin
                    r_state <= S_CLR_WT;
                end
                S_CLR_WT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= dorb_pkg::KIND_DISCARD;
                        r_out_pts   <= r_rdata.pts;
                        r_out_tag   <= dorb_pkg::TAG_IN_W'(r_rdata.tag);
                        r_out_last  <= (r_rd_idx == w_cnt_m1);
                        if (r_rd_idx == w_cnt_m1) begin
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_rd_idx <= r_rd_idx + dorb_pkg::t_cnt'(1);
                            r_state  <= S_CLR_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.kind    = r_out_kind;
    assign o_out.out_pts = r_out_pts;
    assign o_out.out_tag = r_out_tag;
    assign o_out.last    = r_out_last;

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count < dorb_pkg::t_cnt'(dorb_pkg::SLOTS)))
        else $error("store holds too many entries between items");

    a_present_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == dorb_pkg::KIND_PRESENT)) |-> o_out.last)
        else $error("presented frame beat without last");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_OUT) |-> (w_best_idx < r_count))
        else $error("selected entry outside held range");

    a_shift_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend) |-> (r_pend_idx != '0))
        else $error("shift reads from the first slot");

endmodule
